>>> hdl/jnsl_pkg.sv
`default_nettype none

package jnsl_pkg;

  // Scanner modes, one-hot
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SIGN  = 10'b00_0000_0010,
    S_INT   = 10'b00_0000_0100,
    S_FRAC0 = 10'b00_0000_1000,
    S_FRAC  = 10'b00_0001_0000,
    S_EXP0  = 10'b00_0010_0000,
    S_EXPS  = 10'b00_0100_0000,
    S_EXP   = 10'b00_1000_0000,
    S_SBODY = 10'b01_0000_0000,
    S_SESC  = 10'b10_0000_0000
  } scan_mode_e;

  // Request codes on kind
  localparam logic [1:0] REQ_NUM = 2'd1;
  localparam logic [1:0] REQ_STR = 2'd2;

  // Token types
  localparam logic [1:0] TOK_INT   = 2'd0;
  localparam logic [1:0] TOK_FLOAT = 2'd1;
  localparam logic [1:0] TOK_STR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_LONE_MINUS   = 3'd1;
  localparam logic [2:0] ERR_LEAD_ZERO    = 3'd2;
  localparam logic [2:0] ERR_MINUS_ZERO   = 3'd3;
  localparam logic [2:0] ERR_EMPTY_FRAC   = 3'd4;
  localparam logic [2:0] ERR_EMPTY_EXP    = 3'd5;
  localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd6;
  localparam logic [2:0] ERR_UNCLOSED_STR = 3'd7;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  // Counter limits and register reset
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;
  localparam logic [4:0]  TAB_RESET = 5'd8;

endpackage

`default_nettype wire

>>> hdl/json_number_string_lexer_core.sv
// A result beat is registered and becomes valid in the cycle after its character beat is accepted.
// Throughput: one character per cycle; the output register stalls the input only
// while a held result is itself stalled.
// Reset (rst_ni low, asynchronous): idle scanner, line 1, column 0, position 0,
// tab width 8, no result pending.
`default_nettype none

module json_number_string_lexer_core #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // character channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  ch_i,
  // tab width register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      line_number_o,
  output logic [15:0]      column_number_o,
  output logic [15:0]      char_index_o,
  output logic             token_done_o,
  output logic [1:0]       token_kind_out_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic [2:0]       error_code_o,
  output logic             token_active_o
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  jnsl_pkg::scan_mode_e state_q, state_d;
  logic [15:0]              line_q, line_d;
  logic [15:0]              col_q, col_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] begin_q, begin_d;
  logic [1:0]               len_q, len_d;   // integer part length, saturates at 3
  logic                     minus_q, minus_d;
  logic                     lz_q, lz_d;
  logic [4:0]               tab_q;
  logic                     out_valid_q;

  logic        accept;
  logic        is_digit;
  logic        is_exp_ch;
  logic        is_escape;
  logic        floating;
  logic [1:0]  len_inc;
  logic [2:0]  ei_err;
  logic [16:0] col_tab_sum;
  logic [16:0] col_one_sum;
  logic [16:0] line_sum;
  logic        done;
  logic [2:0]  err;
  logic [1:0]  rkind;
  logic [POSITION_BITS-1:0]  tok_len;
  logic [POSITION_BITS+15:0] here_ext;
  logic [POSITION_BITS+15:0] begin_ext;
  logic [POSITION_BITS+15:0] len_ext;

  // Handshakes
  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Character classes
  assign is_digit  = (ch_i >= jnsl_pkg::CH_ZERO) && (ch_i <= jnsl_pkg::CH_NINE);
  assign is_exp_ch = (ch_i == jnsl_pkg::CH_LE) || (ch_i == jnsl_pkg::CH_UE);
  assign is_escape = (ch_i == jnsl_pkg::CH_QUOTE) || (ch_i == jnsl_pkg::CH_BSL) ||
                     (ch_i == jnsl_pkg::CH_SLASH) || (ch_i == jnsl_pkg::CH_B) ||
                     (ch_i == jnsl_pkg::CH_F) || (ch_i == jnsl_pkg::CH_N) ||
                     (ch_i == jnsl_pkg::CH_R) || (ch_i == jnsl_pkg::CH_T);

  // Past the integer part every number is floating
  assign floating = (state_q == jnsl_pkg::S_FRAC0) || (state_q == jnsl_pkg::S_FRAC) ||
                    (state_q == jnsl_pkg::S_EXP0) || (state_q == jnsl_pkg::S_EXPS) ||
                    (state_q == jnsl_pkg::S_EXP);

  assign len_inc = (len_q == 2'd3) ? 2'd3 : len_q + 2'd1;

  // Checks made when the integer part ends
  always_comb begin
    priority if (minus_q && len_q == 2'd1) begin
      ei_err = jnsl_pkg::ERR_LONE_MINUS;
    end else if (!minus_q && lz_q && len_q > 2'd1) begin
      ei_err = jnsl_pkg::ERR_LEAD_ZERO;
    end else if (minus_q && lz_q && len_q > 2'd2) begin
      ei_err = jnsl_pkg::ERR_MINUS_ZERO;
    end else begin
      ei_err = jnsl_pkg::ERR_NONE;
    end
  end

  // Line, column and position counters
  assign col_tab_sum = {1'b0, col_q} + {12'b0, tab_q};
  assign col_one_sum = {1'b0, col_q} + 17'd1;
  assign line_sum    = {1'b0, line_q} + 17'd1;

  always_comb begin
    line_d = line_q;
    if (ch_i == jnsl_pkg::CH_NL) begin
      line_d = line_sum[16] ? jnsl_pkg::CNT_MAX : line_sum[15:0];
      col_d  = 16'd0;
    end else if (ch_i == jnsl_pkg::CH_CR) begin
      col_d = 16'd0;
    end else if (ch_i == jnsl_pkg::CH_TAB) begin
      col_d = col_tab_sum[16] ? jnsl_pkg::CNT_MAX : col_tab_sum[15:0];
    end else begin
      col_d = col_one_sum[16] ? jnsl_pkg::CNT_MAX : col_one_sum[15:0];
    end
  end

  assign pos_d = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;

  // Token scanner
  always_comb begin
    state_d = state_q;
    begin_d = begin_q;
    len_d   = len_q;
    minus_d = minus_q;
    lz_d    = lz_q;
    done    = 1'b0;
    err     = jnsl_pkg::ERR_NONE;
    rkind   = floating ? jnsl_pkg::TOK_FLOAT : jnsl_pkg::TOK_INT;
    unique case (state_q)
      jnsl_pkg::S_IDLE: begin
        if (kind_i == jnsl_pkg::REQ_NUM) begin
          begin_d = pos_q;
          len_d   = 2'd0;
          minus_d = 1'b0;
          lz_d    = 1'b0;
          rkind   = jnsl_pkg::TOK_INT;
          if (ch_i == jnsl_pkg::CH_MINUS) begin
            minus_d = 1'b1;
            len_d   = 2'd1;
            state_d = jnsl_pkg::S_SIGN;
          end else if (is_digit) begin
            lz_d    = (ch_i == jnsl_pkg::CH_ZERO);
            len_d   = 2'd1;
            state_d = jnsl_pkg::S_INT;
          end else if (ch_i == jnsl_pkg::CH_DOT) begin
            state_d = jnsl_pkg::S_FRAC0;
          end else if (is_exp_ch) begin
            state_d = jnsl_pkg::S_EXP0;
          end else begin
            done = 1'b1;
          end
        end else if (kind_i == jnsl_pkg::REQ_STR) begin
          begin_d = pos_d;
          rkind   = jnsl_pkg::TOK_STR;
          if (ch_i == jnsl_pkg::CH_NUL) begin
            err = jnsl_pkg::ERR_UNCLOSED_STR;
          end else begin
            state_d = jnsl_pkg::S_SBODY;
          end
        end
      end
      jnsl_pkg::S_SIGN, jnsl_pkg::S_INT: begin
        if (is_digit) begin
          if (state_q == jnsl_pkg::S_SIGN) begin
            lz_d = (ch_i == jnsl_pkg::CH_ZERO);
          end
          len_d   = len_inc;
          state_d = jnsl_pkg::S_INT;
        end else if (ei_err != jnsl_pkg::ERR_NONE) begin
          err     = ei_err;
          state_d = jnsl_pkg::S_IDLE;
        end else if (ch_i == jnsl_pkg::CH_DOT) begin
          state_d = jnsl_pkg::S_FRAC0;
        end else if (is_exp_ch) begin
          state_d = jnsl_pkg::S_EXP0;
        end else begin
          done    = 1'b1;
          state_d = jnsl_pkg::S_IDLE;
        end
      end
      jnsl_pkg::S_FRAC0: begin
        if (is_digit) begin
          state_d = jnsl_pkg::S_FRAC;
        end else begin
          err     = jnsl_pkg::ERR_EMPTY_FRAC;
          state_d = jnsl_pkg::S_IDLE;
        end
      end
      jnsl_pkg::S_FRAC: begin
        if (is_digit) begin
          state_d = jnsl_pkg::S_FRAC;
        end else if (is_exp_ch) begin
          state_d = jnsl_pkg::S_EXP0;
        end else begin
          done    = 1'b1;
          state_d = jnsl_pkg::S_IDLE;
        end
      end
      jnsl_pkg::S_EXP0: begin
        if (ch_i == jnsl_pkg::CH_PLUS || ch_i == jnsl_pkg::CH_MINUS) begin
          state_d = jnsl_pkg::S_EXPS;
        end else if (is_digit) begin
          state_d = jnsl_pkg::S_EXP;
        end else begin
          err     = jnsl_pkg::ERR_EMPTY_EXP;
          state_d = jnsl_pkg::S_IDLE;
        end
      end
      jnsl_pkg::S_EXPS: begin
        if (is_digit) begin
          state_d = jnsl_pkg::S_EXP;
        end else begin
          err     = jnsl_pkg::ERR_EMPTY_EXP;
          state_d = jnsl_pkg::S_IDLE;
        end
      end
      jnsl_pkg::S_EXP: begin
        if (!is_digit) begin
          done    = 1'b1;
          state_d = jnsl_pkg::S_IDLE;
        end
      end
      jnsl_pkg::S_SBODY: begin
        rkind = jnsl_pkg::TOK_STR;
        if (ch_i == jnsl_pkg::CH_NUL) begin
          err     = jnsl_pkg::ERR_UNCLOSED_STR;
          state_d = jnsl_pkg::S_IDLE;
        end else if (ch_i == jnsl_pkg::CH_QUOTE) begin
          done    = 1'b1;
          state_d = jnsl_pkg::S_IDLE;
        end else if (ch_i == jnsl_pkg::CH_BSL) begin
          state_d = jnsl_pkg::S_SESC;
        end
      end
      jnsl_pkg::S_SESC: begin
        rkind = jnsl_pkg::TOK_STR;
        if (is_escape) begin
          state_d = jnsl_pkg::S_SBODY;
        end else begin
          err     = jnsl_pkg::ERR_BAD_ESCAPE;
          state_d = jnsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = jnsl_pkg::S_IDLE;
      end
    endcase
  end

  // Token length, zero when the start lies past this character
  assign tok_len   = (pos_q >= begin_d) ? pos_q - begin_d : '0;
  assign here_ext  = {16'b0, pos_q};
  assign begin_ext = {16'b0, begin_d};
  assign len_ext   = {16'b0, tok_len};

  // Scanner and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jnsl_pkg::S_IDLE;
      line_q  <= 16'd1;
      col_q   <= 16'd0;
      pos_q   <= '0;
      begin_q <= '0;
      len_q   <= 2'd0;
      minus_q <= 1'b0;
      lz_q    <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
      line_q  <= line_d;
      col_q   <= col_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      len_q   <= len_d;
      minus_q <= minus_d;
      lz_q    <= lz_d;
    end
  end

  // Tab width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q <= jnsl_pkg::TAB_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tab_q <= cfg_data_i;
    end
  end

  // Result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_number_o   <= line_d;
      column_number_o <= col_d;
      char_index_o    <= here_ext[15:0];
      token_done_o    <= done;
      error_code_o    <= err;
      token_active_o  <= (state_d != jnsl_pkg::S_IDLE);
      if (done || err != jnsl_pkg::ERR_NONE) begin
        token_kind_out_o <= rkind;
        token_start_o    <= begin_ext[15:0];
        token_length_o   <= len_ext[15:0];
      end else begin
        token_kind_out_o <= jnsl_pkg::TOK_INT;
        token_start_o    <= 16'd0;
        token_length_o   <= 16'd0;
      end
    end
  end

endmodule

`default_nettype wire
